[rtl/kbd_pkg.sv]
// kbd_pkg: shared types and constants of the knob to backlight duty block
// used by kbd_ctrl, kbd_dpath, kbd_div and the top level
// no dependencies
package kbd_pkg;

  localparam int unsigned LEVEL_W    = 12;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned NUM_W      = 52;  // brightness_max * level^3
  localparam int unsigned DEN_W      = 36;  // top^3
  localparam int unsigned ITER_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned LIN_ITERS  = 28;  // 16 + 12 bit dividend
  localparam int unsigned CUB_ITERS  = 52;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 12'hFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_MAX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TOP_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_STEP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECAL_MARGIN      = 3'd6;

  // register reset values
  localparam logic [DUTY_W-1:0]  RST_BRIGHTNESS_MAX    = 16'd1300;
  localparam logic               RST_CURVE_MODE        = 1'b0;
  localparam logic               RST_AVERAGE_ENABLE    = 1'b1;
  localparam logic [LEVEL_W-1:0] RST_INITIAL_TOP_LEVEL = 12'd3269;
  localparam logic [LEVEL_W-1:0] RST_OFF_LEVEL         = 12'd5;
  localparam logic [LEVEL_W-1:0] RST_CHANGE_STEP       = 12'd5;
  localparam logic [LEVEL_W-1:0] RST_RECAL_MARGIN      = 12'd20;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_AVG,
    OP_EVAL,
    OP_MUL_LL,
    OP_MUL_XL,
    OP_MUL_XM,
    OP_MUL_TT,
    OP_MUL_XT,
    OP_MUL_LIN,
    OP_DIV_DUTY,
    OP_LOAD_DUTY
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   take;
    logic   push;
    logic   push_zero;
    logic   push_last;
  } kbd_cmd_t;

  typedef struct packed {
    logic avg_en;
    logic cnt_last;
    logic started;
    logic off;
    logic adj;
    logic cubic;
    logic div_busy;
    logic out_free;
  } kbd_stat_t;

endpackage

[rtl/kbd_div.sv]
// kbd_div: restoring divider, one quotient bit a cycle
// dividend arrives msb-aligned, iteration count sets the quotient width
// depends on kbd_pkg
module kbd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kbd_pkg::NUM_W-1:0]   dividend_i,
  input  logic [kbd_pkg::DEN_W-1:0]   divisor_i,
  input  logic [kbd_pkg::ITER_W-1:0]  iters_i,
  output logic                        busy_o,
  output logic [kbd_pkg::NUM_W-1:0]   quotient_o
);
  import kbd_pkg::*;

  logic                busy_q, busy_d;
  logic [ITER_W-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [NUM_W-1:0]    quo_q, quo_d;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [DEN_W-1:0]    rem_q, rem_d;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic                ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits DEN_W bits
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q > ITER_W'(1) && !start_i) |=> busy_q)
    else $error("divider stopped early");

endmodule

[rtl/kbd_dpath.sv]
// kbd_dpath: config registers, averaging, level state, shared multiplier,
// divider instance and output register
// depends on kbd_pkg and kbd_div
module kbd_dpath #(
  parameter int unsigned AVG_LEN = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [kbd_pkg::LEVEL_W-1:0]    sample_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [kbd_pkg::DUTY_W-1:0]     duty_o,
  output logic                           last_o,
  input  kbd_pkg::kbd_cmd_t              cmd_i,
  output kbd_pkg::kbd_stat_t             st_o
);
  import kbd_pkg::*;

  localparam int unsigned CNT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;

  // rounded-up reciprocal of AVG_LEN, exact floor mean for any 16-bit sum
  localparam int unsigned      AVG_SH  = SUM_W + $clog2(AVG_LEN);
  localparam logic [DEN_W-1:0] AVG_RCP =
    DEN_W'(((64'd1 << AVG_SH) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));

  // configuration
  logic [DUTY_W-1:0]  bmax_q;
  logic               cubic_q;
  logic               avg_en_q;
  logic [LEVEL_W-1:0] off_lvl_q;
  logic [LEVEL_W-1:0] step_q;
  logic [LEVEL_W-1:0] margin_q;

  // level state
  logic [LEVEL_W-1:0] top_q, top_d;
  logic [LEVEL_W-1:0] prev_q, prev_d;
  logic               started_q, started_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // working registers
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [LEVEL_W-1:0] lv_q, lv_d;
  logic [DEN_W-1:0]   x_q, x_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [DUTY_W-1:0]  res_q, res_d;

  // output register
  logic               ovld_q, ovld_d;
  logic [DUTY_W-1:0]  oduty_q, oduty_d;
  logic               olast_q, olast_d;

  logic [LEVEL_W-1:0] top_eff;
  logic [LEVEL_W-1:0] diff;
  logic               off, adj, cnt_last;
  logic [LEVEL_W-1:0] lv_new;
  logic [DEN_W-1:0]   mul_a;
  logic [DUTY_W-1:0]  mul_b;
  logic [NUM_W-1:0]   prod;

  logic               div_start, div_busy;
  logic [NUM_W-1:0]   div_num, quo;
  logic [DEN_W-1:0]   div_den;
  logic [ITER_W-1:0]  div_iters;
  logic [DUTY_W-1:0]  duty_raw;

  assign top_eff  = (top_q == '0) ? LEVEL_W'(1) : top_q;
  assign diff     = (level_q > prev_q) ? (level_q - prev_q) : (prev_q - level_q);
  assign off      = (level_q < off_lvl_q);
  assign adj      = (diff >= step_q);
  assign lv_new   = off ? '0 : level_q;
  assign cnt_last = (cnt_q == CNT_W'(AVG_LEN - 1));

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_AVG: begin mul_a = AVG_RCP;         mul_b = DUTY_W'(sum_q);   end
      OP_MUL_LL:  begin mul_a = DEN_W'(lv_q);    mul_b = DUTY_W'(lv_q);    end
      OP_MUL_XL:  begin mul_a = x_q;             mul_b = DUTY_W'(lv_q);    end
      OP_MUL_XM:  begin mul_a = x_q;             mul_b = bmax_q;           end
      OP_MUL_TT:  begin mul_a = DEN_W'(top_eff); mul_b = DUTY_W'(top_eff); end
      OP_MUL_XT:  begin mul_a = x_q;             mul_b = DUTY_W'(top_eff); end
      OP_MUL_LIN: begin mul_a = DEN_W'(lv_q);    mul_b = bmax_q;           end
      default:    begin mul_a = '0;              mul_b = '0;               end
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_iters = '0;
    case (cmd_i.op)
      OP_DIV_DUTY: begin
        div_start = 1'b1;
        div_den   = den_q;
        if (cubic_q) begin
          div_num   = num_q;
          div_iters = ITER_W'(CUB_ITERS);
        end else begin
          div_num   = {num_q[LIN_ITERS-1:0], {(NUM_W-LIN_ITERS){1'b0}}};
          div_iters = ITER_W'(LIN_ITERS);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  kbd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // saturate the quotient
  always_comb begin
    if (cubic_q) begin
      duty_raw = (|quo[NUM_W-1:DUTY_W]) ? '1 : quo[DUTY_W-1:0];
    end else if (quo[LIN_ITERS-1:0] > LIN_ITERS'(bmax_q)) begin
      duty_raw = bmax_q;
    end else begin
      duty_raw = quo[DUTY_W-1:0];
    end
  end

  always_comb begin
    top_d     = top_q;
    prev_d    = prev_q;
    started_d = started_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    level_d   = level_q;
    lv_d      = lv_q;
    x_d       = x_q;
    num_d     = num_q;
    den_d     = den_q;
    res_d     = res_q;

    if (cmd_i.take) begin
      if (avg_en_q) begin
        sum_d = sum_q + SUM_W'(sample_i);
        cnt_d = cnt_last ? '0 : cnt_q + 1'b1;
      end else begin
        sum_d   = '0;
        cnt_d   = '0;
        level_d = sample_i;
      end
    end

    case (cmd_i.op)
      OP_MUL_AVG: begin
        // floor mean, only its low 12 bits are kept
        sum_d   = '0;
        level_d = prod[AVG_SH +: LEVEL_W];
      end
      OP_EVAL: begin
        if (!started_q) begin
          // first level only sets up the tracking state
          prev_d    = level_q;
          started_d = 1'b1;
          if (level_q > top_q && level_q != LEVEL_FULL) begin
            top_d = level_q;
          end
        end else begin
          lv_d = lv_new;
          if (adj) begin
            prev_d = lv_new;
            if (lv_new > top_q && (lv_new - top_q) > margin_q && lv_new != LEVEL_FULL) begin
              top_d = lv_new;
            end
          end
        end
      end
      OP_MUL_LL:  x_d   = prod[DEN_W-1:0];
      OP_MUL_XL:  x_d   = prod[DEN_W-1:0];
      OP_MUL_XM:  num_d = prod;
      OP_MUL_TT:  x_d   = prod[DEN_W-1:0];
      OP_MUL_XT:  den_d = prod[DEN_W-1:0];
      OP_MUL_LIN: begin
        num_d = prod;
        den_d = DEN_W'(top_eff);
      end
      OP_LOAD_DUTY: res_d = (duty_raw == '0) ? DUTY_W'(1) : duty_raw;
      default: begin
        res_d = res_q;
      end
    endcase

    if (cfg_we_i && cfg_idx_i == CFG_INITIAL_TOP_LEVEL) begin
      top_d = cfg_data_i[LEVEL_W-1:0];
    end
  end

  // output register, refilled in the cycle it drains
  always_comb begin
    ovld_d  = ovld_q;
    oduty_d = oduty_q;
    olast_d = olast_q;
    if (cmd_i.push) begin
      ovld_d  = 1'b1;
      oduty_d = cmd_i.push_zero ? '0 : res_q;
      olast_d = cmd_i.push_last;
    end else if (ovld_q && !out_stall_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmax_q     <= RST_BRIGHTNESS_MAX;
      cubic_q    <= RST_CURVE_MODE;
      avg_en_q   <= RST_AVERAGE_ENABLE;
      off_lvl_q  <= RST_OFF_LEVEL;
      step_q     <= RST_CHANGE_STEP;
      margin_q   <= RST_RECAL_MARGIN;
      top_q      <= RST_INITIAL_TOP_LEVEL;
      prev_q     <= '0;
      started_q  <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      ovld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BRIGHTNESS_MAX:    bmax_q     <= cfg_data_i;
          CFG_CURVE_MODE:        cubic_q    <= cfg_data_i[0];
          CFG_AVERAGE_ENABLE:    avg_en_q   <= cfg_data_i[0];
          CFG_INITIAL_TOP_LEVEL: ;  // only reloads top_q, through top_d
          CFG_OFF_LEVEL:         off_lvl_q  <= cfg_data_i[LEVEL_W-1:0];
          CFG_CHANGE_STEP:       step_q     <= cfg_data_i[LEVEL_W-1:0];
          CFG_RECAL_MARGIN:      margin_q   <= cfg_data_i[LEVEL_W-1:0];
          default:               bmax_q     <= bmax_q;
        endcase
      end
      top_q     <= top_d;
      prev_q    <= prev_d;
      started_q <= started_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      ovld_q    <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    lv_q    <= lv_d;
    x_q     <= x_d;
    num_q   <= num_d;
    den_q   <= den_d;
    res_q   <= res_d;
    oduty_q <= oduty_d;
    olast_q <= olast_d;
  end

  assign st_o.avg_en   = avg_en_q;
  assign st_o.cnt_last = cnt_last;
  assign st_o.started  = started_q;
  assign st_o.off      = off;
  assign st_o.adj      = adj;
  assign st_o.cubic    = cubic_q;
  assign st_o.div_busy = div_busy;
  assign st_o.out_free = !ovld_q || !out_stall_i;

  assign out_valid_o = ovld_q;
  assign duty_o      = oduty_q;
  assign last_o      = olast_q;

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

endmodule

[rtl/kbd_ctrl.sv]
// kbd_ctrl: sequencer for one level, issues datapath commands
// depends on kbd_pkg
module kbd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kbd_pkg::kbd_stat_t st_i,
  output kbd_pkg::kbd_cmd_t  cmd_o
);
  import kbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG_MUL,
    S_EVAL,
    S_EMIT_OFF,
    S_MUL_LL,
    S_MUL_XL,
    S_MUL_XM,
    S_MUL_TT,
    S_MUL_XT,
    S_MUL_LIN,
    S_DIV,
    S_DIV_WAIT,
    S_EMIT_DUTY
  } state_e;

  state_e state_q, state_d;
  logic   adj_q, adj_d;
  state_e mul_first;

  assign mul_first = st_i.cubic ? S_MUL_LL : S_MUL_LIN;

  always_comb begin
    state_d = state_q;
    adj_d   = adj_q;
    cmd_o   = '{op: OP_NONE, take: 1'b0, push: 1'b0, push_zero: 1'b0, push_last: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (!st_i.avg_en) begin
            state_d = S_EVAL;
          end else if (st_i.cnt_last) begin
            state_d = S_AVG_MUL;
          end
        end
      end
      S_AVG_MUL: begin
        cmd_o.op = OP_MUL_AVG;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.op = OP_EVAL;
        adj_d    = st_i.adj;
        if (!st_i.started) begin
          state_d = S_IDLE;
        end else if (st_i.off) begin
          state_d = S_EMIT_OFF;
        end else if (st_i.adj) begin
          state_d = mul_first;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_OFF: begin
        if (st_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_zero = 1'b1;
          cmd_o.push_last = !adj_q;
          state_d         = adj_q ? mul_first : S_IDLE;
        end
      end
      S_MUL_LL: begin
        cmd_o.op = OP_MUL_LL;
        state_d  = S_MUL_XL;
      end
      S_MUL_XL: begin
        cmd_o.op = OP_MUL_XL;
        state_d  = S_MUL_XM;
      end
      S_MUL_XM: begin
        cmd_o.op = OP_MUL_XM;
        state_d  = S_MUL_TT;
      end
      S_MUL_TT: begin
        cmd_o.op = OP_MUL_TT;
        state_d  = S_MUL_XT;
      end
      S_MUL_XT: begin
        cmd_o.op = OP_MUL_XT;
        state_d  = S_DIV;
      end
      S_MUL_LIN: begin
        cmd_o.op = OP_MUL_LIN;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_DUTY;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!st_i.div_busy) begin
          cmd_o.op = OP_LOAD_DUTY;
          state_d  = S_EMIT_DUTY;
        end
      end
      S_EMIT_DUTY: begin
        if (st_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      adj_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      adj_q   <= adj_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> st_i.out_free)
    else $error("result pushed into a held output register");

  a_emit_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_DUTY || state_q == S_EMIT_OFF) |-> st_i.started)
    else $error("result emitted before the first level");

endmodule

[rtl/knob_to_backlight_duty.sv]
// knob_to_backlight_duty: maps knob samples to a backlight pwm duty
// depends on kbd_pkg, kbd_ctrl, kbd_dpath (and kbd_div below it)
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------
//   input    | in_valid_i   | in_stall_o   | sample_i
//   output   | out_valid_o  | out_stall_i  | duty_o, last_o
//   config   | cfg_we_i     | none         | cfg_idx_i, cfg_data_i
//
// one sample per cycle is taken while no level is in progress; a level
// closing an average first goes through a reciprocal multiply
// a level then runs its multiply steps and the bit-serial divider (28 or 52 bits),
// with an off beat emitted first when the level is off
// reset is asynchronous, active low, and loads the register defaults
// a stalled output holds; the next sample is still taken meanwhile
module knob_to_backlight_duty #(
  parameter int unsigned AVG_LEN = 8  // samples per averaged level, 1 to 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [kbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample beat
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kbd_pkg::LEVEL_W-1:0]    sample_i,
  // duty beat
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kbd_pkg::DUTY_W-1:0]     duty_o,
  output logic                           last_o
);
  import kbd_pkg::*;

  // command and status between sequencer and datapath
  kbd_cmd_t  cmd;
  kbd_stat_t st;

  // sequencer: averaging, evaluation, multiply steps, divide, emit
  kbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath: registers, shared multiplier, divider, output register
  kbd_dpath #(
    .AVG_LEN (AVG_LEN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .duty_o      (duty_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

[tb/tb.sv]
// tb: self-checking bench for knob_to_backlight_duty, one knob sample per input beat
// depends on kbd_pkg and the knob_to_backlight_duty rtl, nothing else
// keeps its own duty predictor and checks every duty beat against it, field by field
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kbd_pkg::*;

  localparam int unsigned AVG_LEN        = 8;
  localparam int unsigned DRAIN_CYCLES   = 200;   // covers the slowest level
  localparam int unsigned LONG_HOLD      = 600;   // receiver hold-off used to fill the block
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any beat
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned GAP_MAX        = 16;

  // index with no register behind it, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              last;
  } duty_beat_t;

  // dut pins, the driven ones known from time zero
  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    knob_sample = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [DUTY_W-1:0]     duty;
  logic                  last;

  // predictor copy of the registers
  logic [DUTY_W-1:0]  cfg_bmax;
  logic               cfg_cubic;
  logic               cfg_avg;
  logic [LEVEL_W-1:0] cfg_off;
  logic [LEVEL_W-1:0] cfg_step;
  logic [LEVEL_W-1:0] cfg_margin;

  // predictor copy of the block state
  logic [LEVEL_W-1:0] knob_top;
  logic [LEVEL_W-1:0] knob_prev;
  logic               knob_started;
  logic [SUM_W-1:0]   knob_sum;
  logic [4:0]         knob_cnt;

  logic [LEVEL_W-1:0] pending_samples[$];  // samples waiting for the driver
  duty_beat_t         duty_expected[$];    // predicted duty beats, oldest first

  int unsigned in_gap_max  = GAP_MAX;
  int unsigned out_gap_max = GAP_MAX;
  int unsigned send_wait   = 0;
  int unsigned recv_wait   = 0;
  int unsigned hold_req    = 0;  // bumped by the stimulus to ask for a long hold-off
  int unsigned hold_seen   = 0;
  int unsigned mismatches  = 0;
  int unsigned beats_seen  = 0;
  int unsigned idle_cycles = 0;
  logic [LEVEL_W-1:0] last_target = '0;
  duty_beat_t         want_beat;

  knob_to_backlight_duty #(
    .AVG_LEN(AVG_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .sample_i   (knob_sample),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .duty_o     (duty),
    .last_o     (last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_predictor();
    cfg_bmax     = RST_BRIGHTNESS_MAX;
    cfg_cubic    = RST_CURVE_MODE;
    cfg_avg      = RST_AVERAGE_ENABLE;
    cfg_off      = RST_OFF_LEVEL;
    cfg_step     = RST_CHANGE_STEP;
    cfg_margin   = RST_RECAL_MARGIN;
    knob_top     = RST_INITIAL_TOP_LEVEL;
    knob_prev    = '0;
    knob_started = 1'b0;
    knob_sum     = '0;
    knob_cnt     = '0;
  endfunction

  // only the low bits of each register survive a write, but the brightness maximum keeps all 16
  function automatic void predict_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BRIGHTNESS_MAX:    cfg_bmax   = data;
      CFG_CURVE_MODE:        cfg_cubic  = data[0];
      CFG_AVERAGE_ENABLE:    cfg_avg    = data[0];
      CFG_INITIAL_TOP_LEVEL: knob_top   = data[LEVEL_W-1:0];  // reloads the top at once
      CFG_OFF_LEVEL:         cfg_off    = data[LEVEL_W-1:0];
      CFG_CHANGE_STEP:       cfg_step   = data[LEVEL_W-1:0];
      CFG_RECAL_MARGIN:      cfg_margin = data[LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // exact integer mapping, a top of zero divides as one
  function automatic logic [DUTY_W-1:0] duty_for(input logic [LEVEL_W-1:0] level);
    logic [63:0] divisor;
    logic [63:0] lv;
    logic [63:0] mx;
    logic [63:0] q;
    divisor = (knob_top == '0) ? 64'd1 : {52'd0, knob_top};
    lv      = {52'd0, level};
    mx      = {48'd0, cfg_bmax};
    if (cfg_cubic) begin
      q = (mx * lv * lv * lv) / (divisor * divisor * divisor);
      if (q > 64'hFFFF) q = 64'hFFFF;
    end else begin
      q = (mx * lv) / divisor;
      if (q > mx) q = mx;
    end
    if (q == 64'd0) q = 64'd1;
    return q[DUTY_W-1:0];
  endfunction

  // one accepted sample in, zero to two duty beats queued
  function automatic void predict_duty(input logic [LEVEL_W-1:0] s);
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] diff;
    logic               off;
    if (cfg_avg) begin
      knob_sum = knob_sum + SUM_W'(s);
      knob_cnt = knob_cnt + 5'd1;
      if (knob_cnt < AVG_LEN) return;
      level    = LEVEL_W'(knob_sum / AVG_LEN);
      knob_sum = '0;
      knob_cnt = '0;
    end else begin
      // averaging off drops any partial sum
      knob_sum = '0;
      knob_cnt = '0;
      level    = s;
    end
    // first level after reset only seeds the history and maybe the top
    if (!knob_started) begin
      knob_prev = level;
      if (level > knob_top && level != LEVEL_FULL) knob_top = level;
      knob_started = 1'b1;
      return;
    end
    // change is judged on the raw level, before the off clamp
    diff = (level > knob_prev) ? level - knob_prev : knob_prev - level;
    off  = (level < cfg_off);
    if (off) level = '0;
    if (diff >= cfg_step) begin
      // off and adjusted: the off beat is not the last one
      if (off) duty_expected.push_back('{duty: '0, last: 1'b0});
      if (level > knob_top && level - knob_top > cfg_margin && level != LEVEL_FULL) begin
        knob_top = level;
      end
      duty_expected.push_back('{duty: duty_for(level), last: 1'b1});
      knob_prev = level;
    end else if (off) begin
      duty_expected.push_back('{duty: '0, last: 1'b1});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued samples, random gap drawn per beat
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_duty(knob_sample);
      // a held beat keeps valid and payload untouched
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          knob_sample <= pending_samples.pop_front();
          in_valid    <= 1'b1;
          send_wait    = $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks duty beats, draws a stall after each one
  // ---------------------------------------------------------------------------

  task automatic flag_beat(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (duty_expected.size() == 0) begin
          flag_beat($sformatf("duty beat %0d unexpected: duty %0d last %0d",
                              beats_seen, duty, last));
        end else begin
          want_beat = duty_expected.pop_front();
          if (duty !== want_beat.duty || last !== want_beat.last) begin
            flag_beat($sformatf("duty beat %0d: expected duty %0d last %0d, got duty %0d last %0d",
                                beats_seen, want_beat.duty, want_beat.last, duty, last));
          end
        end
        recv_wait = $urandom_range(0, out_gap_max);
      end
      // long hold-off asked by the stimulus, counted here
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        recv_wait = LONG_HOLD;
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles with no beat on either side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // wait until every sample is taken and every duty beat seen, then let a
  // level with no duty beat finish inside the block; checked on the falling
  // edge so the driver and monitor have settled for the cycle
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid || duty_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    predict_reg_write(idx, data);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] bmax, input logic [15:0] cubic,
                           input logic [15:0] avg, input logic [15:0] top,
                           input logic [15:0] off, input logic [15:0] step,
                           input logic [15:0] margin);
    write_reg(CFG_BRIGHTNESS_MAX, bmax);
    write_reg(CFG_CURVE_MODE, cubic);
    write_reg(CFG_AVERAGE_ENABLE, avg);
    write_reg(CFG_INITIAL_TOP_LEVEL, top);
    write_reg(CFG_OFF_LEVEL, off);
    write_reg(CFG_CHANGE_STEP, step);
    write_reg(CFG_RECAL_MARGIN, margin);
  endtask

  // mostly in range with the ends favoured, now and then any 16-bit value
  function automatic logic [15:0] pick_reg(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return 16'(lo);
      1:       return 16'(hi);
      2:       return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // level to aim at: anywhere, near the last one, around the off level,
  // around the recalibration threshold, or a rail
  function automatic logic [LEVEL_W-1:0] pick_target();
    int t;
    case ($urandom_range(0, 5))
      0, 1: t = int'($urandom_range(0, 4095));
      2:    t = int'(last_target) + int'($urandom_range(0, 2 * cfg_step + 2)) - int'(cfg_step) - 1;
      3:    t = int'($urandom_range(0, int'(cfg_off) + 2));
      4:    t = int'(knob_top) + int'(cfg_margin) + int'($urandom_range(0, 4)) - 2;
      default: t = ($urandom_range(0, 1) != 0) ? 4095 : 0;
    endcase
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return LEVEL_W'(t);
  endfunction

  // one level: a single sample, or a jittered block of samples with a stray
  // sample now and then when averaging
  function automatic int unsigned queue_level(input logic [LEVEL_W-1:0] target);
    int s;
    last_target = target;
    if (!cfg_avg) begin
      pending_samples.push_back(target);
      return 1;
    end
    for (int k = 0; k < AVG_LEN; k++) begin
      if ($urandom_range(0, 15) == 0) s = int'($urandom_range(0, 4095));
      else s = int'(target) + int'($urandom_range(0, 6)) - 3;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      pending_samples.push_back(LEVEL_W'(s));
    end
    return AVG_LEN;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [LEVEL_W-1:0] seed_run[8];
    logic [LEVEL_W-1:0] lin_run[9];
    int unsigned        queued;
    seed_run = '{12'd4095, 12'd4095, 12'd4095, 12'd4095,
                 12'd3905, 12'd3905, 12'd3905, 12'd3905};
    // off and adjusted, off only, full scale, small change, recalibration,
    // excess under the margin, mid level, at the off level, just under it
    lin_run  = '{12'd0, 12'd2, 12'd4095, 12'd4093, 12'd4060,
                 12'd4070, 12'd2035, 12'd5, 12'd4};

    reset_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first averaged level mean 4000 seeds history and raises the top
    foreach (seed_run[i]) pending_samples.push_back(seed_run[i]);
    wait_drained();
    write_reg(CFG_AVERAGE_ENABLE, 16'd0);
    foreach (lin_run[i]) pending_samples.push_back(lin_run[i]);
    wait_drained();

    // cubic at full brightness, then a top of zero
    write_reg(CFG_CURVE_MODE, 16'd1);
    write_reg(CFG_BRIGHTNESS_MAX, 16'hFFFF);
    pending_samples.push_back(12'd4070);
    pending_samples.push_back(12'd1000);
    wait_drained();
    write_reg(CFG_INITIAL_TOP_LEVEL, 16'd0);
    pending_samples.push_back(12'd10);
    pending_samples.push_back(12'd4095);
    wait_drained();

    // minimum brightness, linear: a zero quotient turns into one
    write_reg(CFG_CURVE_MODE, 16'd0);
    write_reg(CFG_BRIGHTNESS_MAX, 16'd1);
    write_reg(CFG_INITIAL_TOP_LEVEL, 16'd4095);
    pending_samples.push_back(12'd200);
    pending_samples.push_back(12'd4095);
    wait_drained();

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_all(RST_BRIGHTNESS_MAX, 16'(RST_CURVE_MODE), 16'(RST_AVERAGE_ENABLE),
                     16'(RST_INITIAL_TOP_LEVEL), 16'(RST_OFF_LEVEL), 16'(RST_CHANGE_STEP),
                     16'(RST_RECAL_MARGIN));
        1: write_all(16'hFFFF, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd1, 16'd0);
        2: write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd4095, 16'd4095, 16'd4095);
        3: write_all(16'hFFFF, 16'd1, 16'd0, 16'd4095, 16'd0, 16'd1, 16'd0);
        default: begin
          write_all(pick_reg(1, 65535), pick_reg(0, 1), pick_reg(0, 1), pick_reg(1, 4095),
                    pick_reg(0, 4095), pick_reg(1, 4095), pick_reg(0, 4095));
          if (p == 5) write_reg(CFG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
        end
      endcase

      // stretches with no idling on either side, full-rate sender under pressure
      in_gap_max  = (p == 1 || p == 3 || p == 6) ? 0 : GAP_MAX;
      out_gap_max = (p == 1 || p == 6) ? 0 : GAP_MAX;
      // receiver holds off while the sender keeps offering, so the block backs up
      if (p == 3) hold_req++;

      queued = 0;
      while (queued < PHASE_ITEMS) begin
        queued += queue_level(pick_target());
        // sender pauses mid-phase until every duty beat is in
        if (p == 5 && queued >= PHASE_ITEMS / 2 && queued < PHASE_ITEMS / 2 + AVG_LEN) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    if (mismatches == 0 && duty_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
